>>> sv/gpib_device_bus_receiver_assert.svh
// Assertion macros for the bus receiver.
`ifndef GPIB_DEVICE_BUS_RECEIVER_ASSERT_SVH
`define GPIB_DEVICE_BUS_RECEIVER_ASSERT_SVH

`ifndef SYNTH

`define GDBR_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("gdbr: invariant violated");

`define GDBR_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdbr: implication violated");

`define GDBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdbr: next-cycle check violated");

`else

`define GDBR_ASSERT_HOLDS(label, cond)
`define GDBR_ASSERT_IMPLIES(label, ante, cons)
`define GDBR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/gdbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gdbr_pkg;

  localparam logic       OP_STATUS          = 1'b1;

  localparam logic [2:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [2:0] CFG_LISTEN_ONLY    = 3'd1;
  localparam logic [2:0] CFG_EOS_MODE       = 3'd2;
  localparam logic [2:0] CFG_EOT_ENABLE     = 3'd3;
  localparam logic [2:0] CFG_EOT_CHAR       = 3'd4;

  localparam logic [1:0] EOS_CRLF           = 2'd0;
  localparam logic [1:0] EOS_CR             = 2'd1;
  localparam logic [1:0] EOS_LF             = 2'd2;

  localparam logic [7:0] CMD_GROUP_MASK     = 8'h60;
  localparam logic [7:0] CMD_TALK_GROUP     = 8'h40;
  localparam logic [7:0] CMD_LISTEN_GROUP   = 8'h20;
  localparam logic [4:0] CMD_UNADDRESS      = 5'h1F;
  localparam logic [7:0] CMD_SPE            = 8'h18;
  localparam logic [7:0] CMD_SPD            = 8'h19;

  localparam logic [7:0] CHAR_CR            = 8'h0D;
  localparam logic [7:0] CHAR_LF            = 8'h0A;

  localparam int         SRQ_BIT            = 6;

  localparam int         OUT_DATA_W         = 24;

endpackage

`default_nettype wire

>>> sv/gpib_device_bus_receiver.sv
// Channel | Direction | tdata (low bit up)                          | tuser / tlast
// in_     | input     | bus_byte, status_value                      | op, is_command / eoi
// out_    | output    | forward_byte, append_eot, poll_reply, srq,  | forward_valid,
//         |           | talk_addressed, listen_addressed, poll_active | poll_reply_valid
//         |           |                                             | / end_of_burst
// cfg_    | input     | cfg_index selects the register, cfg_data    | none
//
// One item is accepted per cycle unless a held result stalls the input; an item passes the
// input register and then the result register, with all decode between the two.
// While out_tready is low the result holds and one more item waits in the input register.
// Reset clears all flags, the status byte and the configuration registers.
// Configuration writes are always taken and act in the cycle after the transfer.
`timescale 1ns / 1ps
`default_nettype none

`include "gpib_device_bus_receiver_assert.svh"

module gpib_device_bus_receiver
  import gdbr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // bus_byte, status_value
  input  wire logic [1:0]            in_tuser,   // op, is_command
  input  wire logic                  in_tlast,   // eoi
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // forward_byte, append_eot, poll_reply,
                                                 // srq, talk_addressed, listen_addressed,
                                                 // poll_active, zero fill
  output logic [1:0]                 out_tuser,  // forward_valid, poll_reply_valid
  output logic                       out_tlast,  // end_of_burst
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [7:0]            cfg_data
);

  logic       in_v_r;
  logic       in_op_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;
  logic       in_eoi_r;
  logic [7:0] in_status_r;

  logic [4:0] device_address_r;
  logic       listen_only_r;
  logic [1:0] eos_mode_r;
  logic       eot_enable_r;

  logic       talk_flag_r, talk_flag_nxt;
  logic       listen_flag_r, listen_flag_nxt;
  logic       poll_flag_r, poll_flag_nxt;
  logic       prev_was_cr_r, prev_was_cr_nxt;
  logic [7:0] status_byte_r, status_byte_nxt;

  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;
  logic                  out_last_r;

  logic       advance;
  logic       fire;
  logic       cfg_fire;
  logic       listen_force;
  logic       fwd_v, app, burst_end, pr_v;
  logic [7:0] fwd_b, pr;
  logic [4:0] cmd_low;
  logic [7:0] cmd_group;

  assign advance      = !out_v_r || out_tready;
  assign fire         = in_v_r && advance;
  assign in_tready    = !in_v_r || advance;
  assign cfg_ready    = 1'b1;
  assign cfg_fire     = cfg_valid && cfg_ready;
  assign listen_force = cfg_fire && (cfg_index == CFG_LISTEN_ONLY) && cfg_data[0];
  assign cmd_low      = in_byte_r[4:0];
  assign cmd_group    = in_byte_r & CMD_GROUP_MASK;

  always_comb begin
    talk_flag_nxt   = talk_flag_r;
    listen_flag_nxt = listen_flag_r;
    poll_flag_nxt   = poll_flag_r;
    prev_was_cr_nxt = prev_was_cr_r;
    status_byte_nxt = status_byte_r;
    fwd_v           = 1'b0;
    fwd_b           = 8'h00;
    app             = 1'b0;
    burst_end       = 1'b0;
    pr_v            = 1'b0;
    pr              = 8'h00;
    if (in_op_r == OP_STATUS) begin
      status_byte_nxt = in_status_r;
    end else if (in_cmd_r) begin
      prev_was_cr_nxt = 1'b0;
      if (cmd_group == CMD_TALK_GROUP) begin
        if (cmd_low == CMD_UNADDRESS) begin
          talk_flag_nxt = 1'b0;
        end else if (!listen_only_r && cmd_low == device_address_r) begin
          talk_flag_nxt = 1'b1;
          if (!poll_flag_r) begin
            burst_end = 1'b1;
          end else begin
            pr_v                     = 1'b1;
            pr                       = status_byte_r;
            status_byte_nxt[SRQ_BIT] = 1'b0;
          end
        end
      end else if (cmd_group == CMD_LISTEN_GROUP) begin
        if (cmd_low == CMD_UNADDRESS) begin
          if (!listen_only_r) begin
            listen_flag_nxt = 1'b0;
          end
        end else if (cmd_low == device_address_r) begin
          listen_flag_nxt = 1'b1;
        end
      end else if (in_byte_r == CMD_SPE) begin
        poll_flag_nxt = 1'b1;
      end else if (in_byte_r == CMD_SPD) begin
        poll_flag_nxt = 1'b0;
      end
    end else begin
      if (listen_flag_r) begin
        fwd_v = 1'b1;
        fwd_b = in_byte_r;
      end
      if (in_eoi_r) begin
        app       = listen_flag_r && eot_enable_r;
        burst_end = 1'b1;
      end else if (in_byte_r == CHAR_CR) begin
        if (eos_mode_r == EOS_CR) begin
          burst_end = 1'b1;
        end else begin
          prev_was_cr_nxt = 1'b1;
        end
      end else if (in_byte_r == CHAR_LF &&
                   (eos_mode_r == EOS_LF || (prev_was_cr_r && eos_mode_r == EOS_CRLF))) begin
        burst_end = 1'b1;
      end else begin
        prev_was_cr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r     <= in_tuser[0];
      in_cmd_r    <= in_tuser[1];
      in_byte_r   <= in_tdata[7:0];
      in_status_r <= in_tdata[15:8];
      in_eoi_r    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= 5'd0;
      listen_only_r    <= 1'b0;
      eos_mode_r       <= EOS_CRLF;
      eot_enable_r     <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address_r <= cfg_data[4:0];
        CFG_LISTEN_ONLY:    listen_only_r    <= cfg_data[0];
        CFG_EOS_MODE:       eos_mode_r       <= cfg_data[1:0];
        CFG_EOT_ENABLE:     eot_enable_r     <= cfg_data[0];
        CFG_EOT_CHAR: begin
          // The end character itself is inserted on the host side.
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      talk_flag_r   <= 1'b0;
      listen_flag_r <= 1'b0;
      poll_flag_r   <= 1'b0;
      prev_was_cr_r <= 1'b0;
      status_byte_r <= 8'h00;
    end else begin
      if (fire) begin
        talk_flag_r   <= talk_flag_nxt;
        poll_flag_r   <= poll_flag_nxt;
        prev_was_cr_r <= prev_was_cr_nxt;
        status_byte_r <= status_byte_nxt;
      end
      if (fire || listen_force) begin
        listen_flag_r <= (fire ? listen_flag_nxt : listen_flag_r) || listen_force;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_user_r <= {pr_v, fwd_v};
      out_last_r <= burst_end;
      out_data_r <= {3'b000, poll_flag_nxt, listen_flag_nxt, talk_flag_nxt,
                     status_byte_nxt[SRQ_BIT], pr, app, fwd_b};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `GDBR_ASSERT_HOLDS(a_listen_only_listens, !listen_only_r || listen_flag_r)
  `GDBR_ASSERT_IMPLIES(a_poll_reply_talks, out_v_r && out_user_r[1],
                       out_data_r[18] && out_data_r[20] && !out_last_r)
  `GDBR_ASSERT_NEXT(a_input_held, in_v_r && !advance, in_v_r && $stable(in_byte_r))
  `GDBR_ASSERT_NEXT(a_srq_tracks_status, fire, out_data_r[17] == status_byte_r[SRQ_BIT])

endmodule

`default_nettype wire

>>> test/gpib_device_bus_receiver_test.sv
`timescale 1ns / 1ps

module gpib_device_bus_receiver_test;
  import gdbr_pkg::*;

  localparam logic       OP_BUS_BYTE  = 1'b0;
  localparam logic [1:0] EOS_EOI_ONLY = 2'd3;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 150;
  localparam int         STALL_LIMIT  = 2000;

  typedef struct packed {
    logic       fwd_valid;
    logic [7:0] fwd_byte;
    logic       append_eot;
    logic       end_of_burst;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       srq;
    logic       talk;
    logic       listen;
    logic       poll;
  } bus_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [7:0]            cfg_data = '0;

  // Model state and register copies.
  logic       talk_q, listen_q, poll_q, prev_cr_q;
  logic [7:0] status_q;
  logic [4:0] dev_addr_q;
  logic       listen_only_q, eot_en_q;
  logic [1:0] eos_q;
  logic [7:0] eot_char_q;

  bus_result_t expected_results[$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int forwards_seen = 0;
  int bursts_ended = 0;
  int replies_seen = 0;
  int sender_idle_pct = 0;
  int ready_stall_pct = 0;
  int quiet_cycles = 0;

  gpib_device_bus_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void reset_model();
    talk_q = 1'b0;
    listen_q = 1'b0;
    poll_q = 1'b0;
    prev_cr_q = 1'b0;
    status_q = '0;
    dev_addr_q = '0;
    listen_only_q = 1'b0;
    eos_q = EOS_CRLF;
    eot_en_q = 1'b0;
    eot_char_q = '0;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [7:0] value);
    case (idx)
      CFG_DEVICE_ADDRESS: dev_addr_q = value[4:0];
      CFG_LISTEN_ONLY: begin
        listen_only_q = value[0];
        if (value[0]) listen_q = 1'b1;
      end
      CFG_EOS_MODE:   eos_q = value[1:0];
      CFG_EOT_ENABLE: eot_en_q = value[0];
      CFG_EOT_CHAR:   eot_char_q = value;
      default: ;
    endcase
  endfunction

  function automatic bus_result_t decode_bus_item(logic op, logic is_cmd, logic [7:0] b,
                                                  logic eoi, logic [7:0] sv);
    bus_result_t r;
    logic [4:0] low;
    r = '0;
    low = b[4:0];
    if (op == OP_STATUS) begin
      status_q = sv;
    end else if (is_cmd) begin
      prev_cr_q = 1'b0;
      if ((b & CMD_GROUP_MASK) == CMD_TALK_GROUP) begin
        if (low == CMD_UNADDRESS) begin
          talk_q = 1'b0;
        end else if (!listen_only_q && low == dev_addr_q) begin
          talk_q = 1'b1;
          if (!poll_q) begin
            r.end_of_burst = 1'b1;
          end else begin
            r.reply_valid = 1'b1;
            r.reply_byte = status_q;
            status_q[SRQ_BIT] = 1'b0;
          end
        end
      end else if ((b & CMD_GROUP_MASK) == CMD_LISTEN_GROUP) begin
        if (low == CMD_UNADDRESS) begin
          if (!listen_only_q) listen_q = 1'b0;
        end else if (low == dev_addr_q) begin
          listen_q = 1'b1;
        end
      end else if (b == CMD_SPE) begin
        poll_q = 1'b1;
      end else if (b == CMD_SPD) begin
        poll_q = 1'b0;
      end
    end else begin
      if (listen_q) begin
        r.fwd_valid = 1'b1;
        r.fwd_byte = b;
      end
      if (eoi) begin
        r.append_eot = listen_q && eot_en_q;
        r.end_of_burst = 1'b1;
      end else if (b == CHAR_CR) begin
        if (eos_q == EOS_CR) r.end_of_burst = 1'b1;
        else prev_cr_q = 1'b1;
      end else if (b == CHAR_LF &&
                   (eos_q == EOS_LF || (prev_cr_q && eos_q == EOS_CRLF))) begin
        r.end_of_burst = 1'b1;
      end else begin
        prev_cr_q = 1'b0;
      end
    end
    r.srq = status_q[SRQ_BIT];
    r.talk = talk_q;
    r.listen = listen_q;
    r.poll = poll_q;
    return r;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                 name, results_checked, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    bus_result_t seen;
    bus_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.fwd_valid = out_tuser[0];
      seen.reply_valid = out_tuser[1];
      seen.end_of_burst = out_tlast;
      seen.fwd_byte = out_tdata[7:0];
      seen.append_eot = out_tdata[8];
      seen.reply_byte = out_tdata[16:9];
      seen.srq = out_tdata[17];
      seen.talk = out_tdata[18];
      seen.listen = out_tdata[19];
      seen.poll = out_tdata[20];
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result transfer with no item pending: 0x%0h", seen);
      end else begin
        want = expected_results.pop_front();
        compare_field("forward_valid", want.fwd_valid, seen.fwd_valid);
        compare_field("forward_byte", want.fwd_byte, seen.fwd_byte);
        compare_field("append_eot", want.append_eot, seen.append_eot);
        compare_field("end_of_burst", want.end_of_burst, seen.end_of_burst);
        compare_field("poll_reply_valid", want.reply_valid, seen.reply_valid);
        compare_field("poll_reply", want.reply_byte, seen.reply_byte);
        compare_field("srq", want.srq, seen.srq);
        compare_field("talk_addressed", want.talk, seen.talk);
        compare_field("listen_addressed", want.listen, seen.listen);
        compare_field("poll_active", want.poll, seen.poll);
        results_checked++;
        forwards_seen += want.fwd_valid;
        bursts_ended += want.end_of_burst;
        replies_seen += want.reply_valid;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic op, logic is_cmd, logic [7:0] b, logic eoi, logic [7:0] sv);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {sv, b};
    in_tuser <= {is_cmd, op};
    in_tlast <= eoi;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(decode_bus_item(op, is_cmd, b, eoi, sv));
    items_sent++;
  endtask

  task automatic send_cmd(logic [7:0] b);
    send_item(OP_BUS_BYTE, 1'b1, b, 1'($urandom), 8'($urandom));
  endtask

  task automatic send_data(logic [7:0] b, logic eoi);
    send_item(OP_BUS_BYTE, 1'b0, b, eoi, 8'($urandom));
  endtask

  task automatic send_status(logic [7:0] sv);
    send_item(OP_STATUS, 1'($urandom), 8'($urandom), 1'($urandom), sv);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
  endtask

  task automatic configure(logic [4:0] addr, logic lonly, logic [1:0] eos, logic eot_en,
                           logic [7:0] eot_ch);
    wait_idle();
    write_reg(CFG_DEVICE_ADDRESS, {3'b000, addr});
    write_reg(CFG_LISTEN_ONLY, {7'd0, lonly});
    write_reg(CFG_EOS_MODE, {6'd0, eos});
    write_reg(CFG_EOT_ENABLE, {7'd0, eot_en});
    write_reg(CFG_EOT_CHAR, eot_ch);
    cfg_valid <= 1'b0;
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      1: begin sender_idle_pct = 51; ready_stall_pct = 0; end
      2: begin sender_idle_pct = 0; ready_stall_pct = 51; end
      3: begin sender_idle_pct = 17; ready_stall_pct = 17; end
      default: begin sender_idle_pct = 0; ready_stall_pct = 0; end
    endcase
  endtask

  function automatic logic [7:0] pick_data_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return CHAR_CR;
    if (pick < 40) return CHAR_LF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] address_cmd(logic [7:0] group, logic [4:0] addr);
    return group | {1'($urandom_range(1)), 2'b00, addr};
  endfunction

  task automatic test_addressing();
    configure(5'd30, 1'b0, EOS_CRLF, 1'b1, 8'hFF);
    send_data(8'h00, 1'b0);
    send_cmd(CMD_LISTEN_GROUP | 8'd30);
    send_data(8'hFF, 1'b1);
    send_cmd(8'h80 | CMD_TALK_GROUP | 8'd30);
    send_cmd(CMD_TALK_GROUP | CMD_UNADDRESS);
    send_cmd(CMD_LISTEN_GROUP | CMD_UNADDRESS);
    send_cmd(CMD_GROUP_MASK | 8'd30);
  endtask

  task automatic test_end_marks();
    send_cmd(CMD_LISTEN_GROUP | 8'd30);
    send_data(CHAR_CR, 1'b0);
    send_data(CHAR_LF, 1'b0);
    send_data(CHAR_CR, 1'b0);
    send_data(8'h41, 1'b0);
    send_data(CHAR_LF, 1'b0);
  endtask

  task automatic test_serial_poll();
    wait_idle();
    send_status(8'hFF);
    send_cmd(CMD_SPE);
    send_cmd(CMD_TALK_GROUP | 8'd30);
    send_cmd(CMD_TALK_GROUP | 8'd30);
    send_cmd(CMD_SPD);
    send_status(8'h00);
  endtask

  task automatic test_listen_only();
    configure(5'd30, 1'b1, EOS_LF, 1'b0, 8'h00);
    send_cmd(CMD_LISTEN_GROUP | CMD_UNADDRESS);
    send_cmd(CMD_TALK_GROUP | 8'd30);
    send_data(CHAR_LF, 1'b0);
    send_data(CHAR_CR, 1'b0);
  endtask

  task automatic run_scenario();
    int kind;
    int count;
    int term;
    kind = $urandom_range(99);
    if (kind < 30) begin
      if ($urandom_range(1)) send_cmd(address_cmd(CMD_LISTEN_GROUP, CMD_UNADDRESS));
      send_cmd(address_cmd(CMD_LISTEN_GROUP, dev_addr_q));
      count = $urandom_range(1, 8);
      repeat (count) send_data(pick_data_byte(), $urandom_range(19) == 0);
      term = $urandom_range(3);
      case (term)
        0: send_data(8'($urandom), 1'b1);
        1: begin send_data(CHAR_CR, 1'b0); send_data(CHAR_LF, 1'b0); end
        2: send_data(CHAR_LF, 1'b0);
        default: send_data(CHAR_CR, 1'b0);
      endcase
      if ($urandom_range(1)) send_cmd(address_cmd(CMD_LISTEN_GROUP, CMD_UNADDRESS));
    end else if (kind < 40) begin
      send_cmd(address_cmd(CMD_TALK_GROUP, dev_addr_q));
      if ($urandom_range(1)) send_cmd(address_cmd(CMD_TALK_GROUP, CMD_UNADDRESS));
    end else if (kind < 60) begin
      if ($urandom_range(1)) send_status(8'($urandom) | 8'h40);
      send_cmd(CMD_SPE);
      send_cmd(address_cmd(CMD_TALK_GROUP, dev_addr_q));
      if ($urandom_range(1)) send_cmd(address_cmd(CMD_TALK_GROUP, dev_addr_q));
      send_cmd(address_cmd(CMD_TALK_GROUP, CMD_UNADDRESS));
      send_cmd(CMD_SPD);
    end else if (kind < 70) begin
      send_status(8'($urandom));
    end else if (kind < 90) begin
      count = $urandom_range(1, 4);
      repeat (count)
        send_item(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    end else begin
      send_cmd(address_cmd($urandom_range(1) ? CMD_TALK_GROUP : CMD_LISTEN_GROUP,
                           5'($urandom_range(31))));
    end
  endtask

  task automatic test_random_traffic();
    int limit;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: configure(5'd0, 1'b0, EOS_CRLF, 1'b1, 8'hFF);
        1: configure(5'd30, 1'b0, EOS_CR, 1'b0, 8'h00);
        2: configure(5'($urandom_range(30)), 1'b1, EOS_LF, 1'b1, 8'($urandom));
        3: configure(5'($urandom_range(30)), 1'b0, EOS_EOI_ONLY, 1'b1, CHAR_LF);
        default: configure(5'($urandom_range(30)), $urandom_range(3) == 0,
                           2'($urandom), 1'($urandom), 8'($urandom));
      endcase
      set_idle_mode(phase % 4);
      limit = items_sent + PHASE_ITEMS;
      while (items_sent < limit) run_scenario();
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idle_mode(0);
    test_addressing();
    test_end_marks();
    test_serial_poll();
    test_listen_only();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Sent %0d bus and status items over %0d register settings and four idle modes.",
             items_sent, PHASES + 2);
    $display("Checked %0d results: %0d forwarded bytes, %0d burst ends, %0d poll replies.",
             results_checked, forwards_seen, bursts_ended, replies_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/gdbr_pkg.sv
sv/gpib_device_bus_receiver.sv
test/gpib_device_bus_receiver_test.sv
